@@ src/clet_pkg.sv @@
// Shared constants, codes and helper functions for the console line editor.
package clet_pkg;

   // Default sizing of the line store and the token limit.
   localparam int unsigned DEFAULT_BUFFER_DEPTH = 1024;
   localparam int unsigned DEFAULT_MAX_ARGS     = 10;

   // Fixed widths of the item fields.
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 10;
   localparam int unsigned ARGC_W = 4;

   // Length of the exit word.
   localparam int unsigned EXIT_LEN = 4;

   // Request operation codes.
   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Result kind codes.
   localparam logic [1:0] KIND_ECHO    = 2'd0;
   localparam logic [1:0] KIND_TOKEN   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

   // Character of the exit word at a given position.
   function automatic logic [BYTE_W-1:0] exit_char(input logic [1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         2'd0:    c = 8'h65;
         2'd1:    c = 8'h78;
         2'd2:    c = 8'h69;
         default: c = 8'h74;
      endcase
      return c;
   endfunction

endpackage

@@ src/clet_ram.sv @@
// Single-port line store with registered read.
module clet_ram
   import clet_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_BUFFER_DEPTH,
   parameter int unsigned AW    = $clog2(DEFAULT_BUFFER_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [AW-1:0]     addr,
   input  logic [BYTE_W-1:0] wr_data,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write and registered read share the one address port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/console_line_editor_tokenizer_top.sv @@
// Top level of the console line editor: edit control, tokenizer walk and result register.
//
// Each item is either a received console byte or a read of the line store, and the
// block works on one item at a time. A printable byte is stored, then echoed; a
// backspace echoes backspace, space, backspace; a read reads the memory, then gives the
// result. An end-of-line byte is taken in and echoed as CR and LF; the tokenizer walk
// then reads and checks each line position in turn, gives a tail token when the last
// token runs to the end of the line, and ends with the summary; the walk stops early at
// the token limit. The single-port line memory has a registered read, so the walk reads
// each position in ST_SCAN_RD and checks the data in ST_SCAN_CHK. A held result register
// parts the output from the walk, so each result also waits for the receiver.
// The line store needs no clearing pass after reset; reading a position never written
// returns whatever the memory holds.
module console_line_editor_tokenizer_top
   import clet_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
   parameter int unsigned MAX_ARGS     = DEFAULT_MAX_ARGS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic [POS_W-1:0]  req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic [POS_W-1:0]  rsp_token_start,
   output logic [POS_W-1:0]  rsp_token_length,
   output logic [POS_W-1:0]  rsp_line_length,
   output logic [ARGC_W-1:0] rsp_token_total,
   output logic              rsp_too_many_args,
   output logic              rsp_is_exit,
   output logic              rsp_last
);

   localparam int unsigned AW = $clog2(BUFFER_DEPTH);
   localparam int unsigned CW = $clog2(MAX_ARGS + 1);
   localparam logic [AW-1:0] EDIT_MAX = AW'(BUFFER_DEPTH - 2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_READ_OUT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_TAIL_TOK,
      ST_SUMMARY
   } state_type;

   typedef enum logic [1:0] {
      SEQ_CHAR,
      SEQ_ERASE,
      SEQ_NEWLINE
   } seq_type;

   state_type state_ff, state_in;
   seq_type   seq_ff, seq_in;

   logic [1:0]        echo_idx_ff, echo_idx_in;
   logic [BYTE_W-1:0] char_ff, char_in;
   logic [AW-1:0]     edit_len_ff, edit_len_in;
   logic [AW-1:0]     line_len_ff, line_len_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     start_ff, start_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              too_ff, too_in;
   logic              in_tok_ff, in_tok_in;
   logic              exit_ok_ff, exit_ok_in;
   logic              read_oor_ff, read_oor_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]  rsp_tstart_ff, rsp_tstart_in;
   logic [POS_W-1:0]  rsp_tlen_ff, rsp_tlen_in;
   logic [POS_W-1:0]  rsp_llen_ff, rsp_llen_in;
   logic [ARGC_W-1:0] rsp_argc_ff, rsp_argc_in;
   logic              rsp_too_ff, rsp_too_in;
   logic              rsp_exit_ff, rsp_exit_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wdata, mem_rdata;

   logic              accept, slot_free, is_print, at_end, seq_done;
   logic [AW-1:0]     pos_next;
   logic [CW-1:0]     count_next;

   logic              emit, e_tm, e_ex, e_last;
   logic [1:0]        e_kind;
   logic [BYTE_W-1:0] e_data;
   logic [AW-1:0]     e_ts, e_tl, e_ll;
   logic [CW-1:0]     e_ac;

   clet_ram #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Handshake and shared decode.
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign is_print   = (req_rx_byte >= CH_SP) && (req_rx_byte <= CH_TILDE);
   assign pos_next   = pos_ff + AW'(1);
   assign at_end     = (pos_next == line_len_ff);
   assign count_next = count_ff + CW'(1);

   // Echo sequence progress.
   always_comb begin
      case (seq_ff)
         SEQ_CHAR:  seq_done = (echo_idx_ff == 2'd0);
         SEQ_ERASE: seq_done = (echo_idx_ff == 2'd2);
         default:   seq_done = (echo_idx_ff == 2'd1);
      endcase
   end

   // Next-state, memory control and result selection.
   always_comb begin
      state_in    = state_ff;
      seq_in      = seq_ff;
      echo_idx_in = echo_idx_ff;
      char_in     = char_ff;
      edit_len_in = edit_len_ff;
      line_len_in = line_len_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      too_in      = too_ff;
      in_tok_in   = in_tok_ff;
      exit_ok_in  = exit_ok_ff;
      read_oor_in = read_oor_ff;

      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = pos_ff;
      mem_wdata = req_rx_byte;

      emit   = 1'b0;
      e_kind = KIND_ECHO;
      e_data = '0;
      e_ts   = '0;
      e_tl   = '0;
      e_ll   = '0;
      e_ac   = '0;
      e_tm   = 1'b0;
      e_ex   = 1'b0;
      e_last = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_READ) begin
                  mem_re      = 1'b1;
                  mem_addr    = AW'(req_read_index);
                  read_oor_in = (32'(req_read_index) >= 32'(BUFFER_DEPTH));
                  state_in    = ST_READ_OUT;
               end else if ((req_rx_byte == CH_BS) || (req_rx_byte == CH_DEL)) begin
                  if (edit_len_ff != '0) begin
                     edit_len_in = edit_len_ff - AW'(1);
                     seq_in      = SEQ_ERASE;
                     echo_idx_in = 2'd0;
                     state_in    = ST_ECHO;
                  end
               end else if ((req_rx_byte == CH_CR) || (req_rx_byte == CH_LF)) begin
                  line_len_in = edit_len_ff;
                  edit_len_in = '0;
                  seq_in      = SEQ_NEWLINE;
                  echo_idx_in = 2'd0;
                  state_in    = ST_ECHO;
               end else if (is_print && (edit_len_ff < EDIT_MAX)) begin
                  mem_we      = 1'b1;
                  mem_addr    = edit_len_ff;
                  edit_len_in = edit_len_ff + AW'(1);
                  char_in     = req_rx_byte;
                  seq_in      = SEQ_CHAR;
                  echo_idx_in = 2'd0;
                  state_in    = ST_ECHO;
               end
            end
         end

         ST_ECHO: begin
            emit = 1'b1;
            case (seq_ff)
               SEQ_CHAR:  e_data = char_ff;
               SEQ_ERASE: e_data = (echo_idx_ff == 2'd1) ? CH_SP : CH_BS;
               default:   e_data = (echo_idx_ff == 2'd0) ? CH_CR : CH_LF;
            endcase
            e_last = seq_done && (seq_ff != SEQ_NEWLINE);
            if (slot_free) begin
               echo_idx_in = echo_idx_ff + 2'd1;
               if (seq_done) begin
                  if (seq_ff == SEQ_NEWLINE) begin
                     pos_in     = '0;
                     start_in   = '0;
                     count_in   = '0;
                     too_in     = 1'b0;
                     in_tok_in  = 1'b0;
                     exit_ok_in = 1'b1;
                     state_in   = (line_len_ff == '0) ? ST_SUMMARY : ST_SCAN_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         ST_READ_OUT: begin
            emit   = 1'b1;
            e_kind = KIND_READ;
            e_data = read_oor_ff ? '0 : mem_rdata;
            e_last = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN_RD: begin
            mem_re   = 1'b1;
            mem_addr = pos_ff;
            state_in = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            // The exit word is checked against the first four positions.
            if ((pos_ff < AW'(EXIT_LEN)) && (mem_rdata != exit_char(pos_ff[1:0]))) begin
               exit_ok_in = 1'b0;
            end
            if (!in_tok_ff) begin
               // Skipping leading spaces until the first token begins.
               if (mem_rdata != CH_SP) begin
                  if (count_next == CW'(MAX_ARGS)) begin
                     too_in   = 1'b1;
                     count_in = '0;
                     state_in = ST_SUMMARY;
                  end else begin
                     in_tok_in = 1'b1;
                     start_in  = pos_ff;
                     count_in  = count_next;
                     pos_in    = pos_next;
                     state_in  = at_end ? ST_TAIL_TOK : ST_SCAN_RD;
                  end
               end else begin
                  pos_in   = pos_next;
                  state_in = at_end ? ST_SUMMARY : ST_SCAN_RD;
               end
            end else if (mem_rdata == CH_SP) begin
               // A space closes the current token.
               emit   = 1'b1;
               e_kind = KIND_TOKEN;
               e_ts   = start_ff;
               e_tl   = pos_ff - start_ff;
               if (slot_free) begin
                  if (at_end) begin
                     in_tok_in = 1'b0;
                     state_in  = ST_SUMMARY;
                  end else if (count_next == CW'(MAX_ARGS)) begin
                     too_in   = 1'b1;
                     count_in = '0;
                     state_in = ST_SUMMARY;
                  end else begin
                     count_in = count_next;
                     start_in = pos_next;
                     pos_in   = pos_next;
                     state_in = ST_SCAN_RD;
                  end
               end
            end else begin
               pos_in   = pos_next;
               state_in = at_end ? ST_TAIL_TOK : ST_SCAN_RD;
            end
         end

         ST_TAIL_TOK: begin
            emit   = 1'b1;
            e_kind = KIND_TOKEN;
            e_ts   = start_ff;
            e_tl   = line_len_ff - start_ff;
            if (slot_free) begin
               state_in = ST_SUMMARY;
            end
         end

         ST_SUMMARY: begin
            emit   = 1'b1;
            e_kind = KIND_SUMMARY;
            e_ll   = line_len_ff;
            e_ac   = count_ff;
            e_tm   = too_ff;
            e_ex   = exit_ok_ff && (line_len_ff == AW'(EXIT_LEN));
            e_last = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register loads whenever the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tstart_in = rsp_tstart_ff;
      rsp_tlen_in   = rsp_tlen_ff;
      rsp_llen_in   = rsp_llen_ff;
      rsp_argc_in   = rsp_argc_ff;
      rsp_too_in    = rsp_too_ff;
      rsp_exit_in   = rsp_exit_ff;
      rsp_last_in   = rsp_last_ff;
      if (slot_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_kind_in   = e_kind;
            rsp_data_in   = e_data;
            rsp_tstart_in = POS_W'(e_ts);
            rsp_tlen_in   = POS_W'(e_tl);
            rsp_llen_in   = POS_W'(e_ll);
            rsp_argc_in   = ARGC_W'(e_ac);
            rsp_too_in    = e_tm;
            rsp_exit_in   = e_ex;
            rsp_last_in   = e_last;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edit_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edit_len_ff  <= edit_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seq_ff        <= seq_in;
      echo_idx_ff   <= echo_idx_in;
      char_ff       <= char_in;
      line_len_ff   <= line_len_in;
      pos_ff        <= pos_in;
      start_ff      <= start_in;
      count_ff      <= count_in;
      too_ff        <= too_in;
      in_tok_ff     <= in_tok_in;
      exit_ok_ff    <= exit_ok_in;
      read_oor_ff   <= read_oor_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_tstart_ff <= rsp_tstart_in;
      rsp_tlen_ff   <= rsp_tlen_in;
      rsp_llen_ff   <= rsp_llen_in;
      rsp_argc_ff   <= rsp_argc_in;
      rsp_too_ff    <= rsp_too_in;
      rsp_exit_ff   <= rsp_exit_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_data_byte     = rsp_data_ff;
   assign rsp_token_start   = rsp_tstart_ff;
   assign rsp_token_length  = rsp_tlen_ff;
   assign rsp_line_length   = rsp_llen_ff;
   assign rsp_token_total   = rsp_argc_ff;
   assign rsp_too_many_args = rsp_too_ff;
   assign rsp_is_exit       = rsp_exit_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTH
   // The edit line never grows past the store limit.
   a_edit_len_limit: assert property (@(posedge clock) disable iff (reset)
      edit_len_ff <= EDIT_MAX)
      else $error("edit line length beyond limit");

   // The walk only reads positions inside the finished line.
   a_scan_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_RD) |-> (pos_ff < line_len_ff))
      else $error("tokenizer walk past end of line");

   // The edit length only changes on an accepted item.
   a_edit_len_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(edit_len_ff))
      else $error("edit length changed without an accepted item");

   // A line summary always closes the item and too many tokens clear the count.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_SUMMARY)) |-> rsp_last_ff)
      else $error("summary result not marked last");

   a_too_many_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_too_ff) |-> (rsp_argc_ff == '0))
      else $error("token count not cleared on overflow");
`endif

endmodule

@@ dv/console_line_editor_result_check.sv @@
// Checker for the console line editor: predicts the results of each item and compares them.
`timescale 1ns / 1ps
module console_line_editor_result_check
   import clet_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic [POS_W-1:0]  req_read_index,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_kind,
   input  logic [BYTE_W-1:0] rsp_data_byte,
   input  logic [POS_W-1:0]  rsp_token_start,
   input  logic [POS_W-1:0]  rsp_token_length,
   input  logic [POS_W-1:0]  rsp_line_length,
   input  logic [ARGC_W-1:0] rsp_token_total,
   input  logic              rsp_too_many_args,
   input  logic              rsp_is_exit,
   input  logic              rsp_last,
   output int                mismatch_count,
   output int                pending_results
);

   localparam int unsigned BUF_DEPTH  = DEFAULT_BUFFER_DEPTH;
   localparam int unsigned MAX_TOKENS = DEFAULT_MAX_ARGS;
   localparam int          PRINT_CAP  = 100;

   typedef struct {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data_byte;
      logic [POS_W-1:0]  token_start;
      logic [POS_W-1:0]  token_length;
      logic [POS_W-1:0]  line_length;
      logic [ARGC_W-1:0] token_total;
      logic              too_many_args;
      logic              is_exit;
      logic              last;
   } tty_result_type;

   // Shadow of the edit line and the results still owed by the block.
   logic [BYTE_W-1:0] line_buf [BUF_DEPTH];
   int unsigned       edit_len;
   tty_result_type    expected_q[$];
   int                mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [POS_W-1:0] got,
                              input logic [POS_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic add_result(input logic [1:0] kind, input logic [BYTE_W-1:0] data,
                             input int unsigned start, input int unsigned length,
                             input int unsigned line_len, input int unsigned argc,
                             input logic too_many, input logic exit_word);
      tty_result_type r;
      r.kind          = kind;
      r.data_byte     = data;
      r.token_start   = POS_W'(start);
      r.token_length  = POS_W'(length);
      r.line_length   = POS_W'(line_len);
      r.token_total   = ARGC_W'(argc);
      r.too_many_args = too_many;
      r.is_exit       = exit_word;
      r.last          = 1'b0;
      expected_q.push_back(r);
   endtask

   // Split the finished line into tokens, then add the line summary.
   task automatic split_line();
      int unsigned pos;
      int unsigned scan;
      int unsigned count;
      logic        too_many;
      logic        exit_word;
      logic        done;
      pos      = 0;
      count    = 0;
      too_many = 1'b0;
      while (pos < edit_len && line_buf[pos] == CH_SP)
         pos++;
      done = (pos >= edit_len);
      while (!done) begin
         count++;
         if (count == MAX_TOKENS) begin
            // The token that reaches the limit is dropped and the count is cleared.
            too_many = 1'b1;
            count    = 0;
            done     = 1'b1;
         end else begin
            scan = pos;
            while (scan < edit_len && line_buf[scan] != CH_SP)
               scan++;
            add_result(KIND_TOKEN, '0, pos, scan - pos, 0, 0, 1'b0, 1'b0);
            if (scan >= edit_len) begin
               done = 1'b1;
            end else begin
               pos  = scan + 1;
               done = (pos >= edit_len);
            end
         end
      end
      exit_word = (edit_len == EXIT_LEN) &&
                  ({line_buf[0], line_buf[1], line_buf[2], line_buf[3]} == "exit");
      add_result(KIND_SUMMARY, '0, 0, 0, edit_len, count, too_many, exit_word);
      edit_len = 0;
   endtask

   // Work out the results of one accepted item and mark the final one.
   task automatic predict_results(input logic op, input logic [BYTE_W-1:0] ch,
                                  input logic [POS_W-1:0] idx);
      int unsigned    first;
      tty_result_type tail;
      first = expected_q.size();
      if (op == OP_READ) begin
         add_result(KIND_READ, (idx < BUF_DEPTH) ? line_buf[idx] : '0, 0, 0, 0, 0, 1'b0, 1'b0);
      end else if (ch == CH_BS || ch == CH_DEL) begin
         if (edit_len > 0) begin
            edit_len--;
            add_result(KIND_ECHO, CH_BS, 0, 0, 0, 0, 1'b0, 1'b0);
            add_result(KIND_ECHO, CH_SP, 0, 0, 0, 0, 1'b0, 1'b0);
            add_result(KIND_ECHO, CH_BS, 0, 0, 0, 0, 1'b0, 1'b0);
         end
      end else if (ch == CH_CR || ch == CH_LF) begin
         add_result(KIND_ECHO, CH_CR, 0, 0, 0, 0, 1'b0, 1'b0);
         add_result(KIND_ECHO, CH_LF, 0, 0, 0, 0, 1'b0, 1'b0);
         split_line();
      end else if (ch >= CH_SP && ch <= CH_TILDE && edit_len < BUF_DEPTH - 2) begin
         line_buf[edit_len] = ch;
         edit_len++;
         add_result(KIND_ECHO, ch, 0, 0, 0, 0, 1'b0, 1'b0);
      end
      if (expected_q.size() > first) begin
         tail      = expected_q.pop_back();
         tail.last = 1'b1;
         expected_q.push_back(tail);
      end
   endtask

   // Compare each accepted result with the oldest expectation, then predict new items.
   always @(posedge clock) begin : watch_channels
      tty_result_type want;
      if (reset) begin
         expected_q.delete();
         edit_len = 0;
         pending_results <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result of kind %0d with none expected", rsp_kind));
            end else begin
               want = expected_q.pop_front();
               check_field("kind", POS_W'(rsp_kind), POS_W'(want.kind));
               check_field("data_byte", POS_W'(rsp_data_byte), POS_W'(want.data_byte));
               check_field("token_start", rsp_token_start, want.token_start);
               check_field("token_length", rsp_token_length, want.token_length);
               check_field("line_length", rsp_line_length, want.line_length);
               check_field("token_total", POS_W'(rsp_token_total), POS_W'(want.token_total));
               check_field("too_many_args", POS_W'(rsp_too_many_args),
                           POS_W'(want.too_many_args));
               check_field("is_exit", POS_W'(rsp_is_exit), POS_W'(want.is_exit));
               check_field("last", POS_W'(rsp_last), POS_W'(want.last));
            end
         end
         if (req_valid && !req_stall)
            predict_results(req_op, req_rx_byte, req_read_index);
         pending_results <= expected_q.size();
      end
   end

endmodule

@@ dv/console_line_editor_tokenizer_top_test.sv @@
// Testbench top for the console line editor: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module console_line_editor_tokenizer_top_test;
   import clet_pkg::*;

   localparam int unsigned LINE_LIMIT      = DEFAULT_BUFFER_DEPTH - 2;
   localparam int unsigned STALL_LIMIT     = 20000;
   localparam int unsigned ITEMS_PER_PHASE = 80;
   localparam int unsigned SETTLE_CYCLES   = 40;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic              req_op         = OP_RX;
   logic [BYTE_W-1:0] req_rx_byte    = '0;
   logic [POS_W-1:0]  req_read_index = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [1:0]        rsp_kind;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic [POS_W-1:0]  rsp_token_start;
   logic [POS_W-1:0]  rsp_token_length;
   logic [POS_W-1:0]  rsp_line_length;
   logic [ARGC_W-1:0] rsp_token_total;
   logic              rsp_too_many_args;
   logic              rsp_is_exit;
   logic              rsp_last;

   int                mismatch_count;
   int                pending_results;
   int unsigned       send_idle_pct  = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       idle_cycles    = 0;

   // Stimulus-side bookkeeping: the fills keep reads on written positions, the item count sets the phase length.
   int unsigned       line_fill  = 0;
   int unsigned       store_fill = 0;
   int unsigned       items_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   console_line_editor_tokenizer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_rx_byte       (req_rx_byte),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_line_length   (rsp_line_length),
      .rsp_token_total   (rsp_token_total),
      .rsp_too_many_args (rsp_too_many_args),
      .rsp_is_exit       (rsp_is_exit),
      .rsp_last          (rsp_last)
   );

   console_line_editor_result_check echo_token_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_rx_byte       (req_rx_byte),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_line_length   (rsp_line_length),
      .rsp_token_total   (rsp_token_total),
      .rsp_too_many_args (rsp_too_many_args),
      .rsp_is_exit       (rsp_is_exit),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .pending_results   (pending_results)
   );

   // The receiver stalls at random.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // The run ends if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("** console_line_editor_tokenizer_top: FAILED **");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until it is accepted.
   task automatic send_item(input logic op, input logic [BYTE_W-1:0] ch,
                            input logic [POS_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_rx_byte    <= ch;
      req_read_index <= idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // Ignored bytes do not count toward the item totals.
      if (op == OP_READ) begin
         items_sent++;
      end else if (ch == CH_BS || ch == CH_DEL) begin
         if (line_fill > 0)
            line_fill--;
         items_sent++;
      end else if (ch == CH_CR || ch == CH_LF) begin
         line_fill = 0;
         items_sent++;
      end else if (ch >= CH_SP && ch <= CH_TILDE) begin
         if (line_fill < LINE_LIMIT) begin
            line_fill++;
            if (line_fill > store_fill)
               store_fill = line_fill;
         end
         items_sent++;
      end
   endtask

   task automatic type_byte(input logic [BYTE_W-1:0] ch);
      send_item(OP_RX, ch, POS_W'($urandom));
   endtask

   task automatic type_text(input string s);
      for (int i = 0; i < s.len(); i++)
         type_byte(s[i]);
   endtask

   // Read a line store position that has been written at some point.
   task automatic read_back();
      if (store_fill > 0)
         send_item(OP_READ, BYTE_W'($urandom), POS_W'($urandom_range(store_fill - 1)));
   endtask

   function automatic logic [BYTE_W-1:0] printable_byte();
      return BYTE_W'($urandom_range(CH_TILDE, CH_SP + 8'd1));
   endfunction

   function automatic logic [BYTE_W-1:0] ignored_byte();
      logic [BYTE_W-1:0] b;
      do
         b = BYTE_W'($urandom);
      while ((b >= CH_SP && b <= CH_TILDE) || b == CH_BS || b == CH_DEL ||
             b == CH_CR || b == CH_LF);
      return b;
   endfunction

   // Stop sending until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   // One typed line: words with random content, some edits, noise and reads, then an end byte.
   task automatic type_random_line();
      int unsigned style;
      int unsigned word_total;
      style      = $urandom_range(99);
      word_total = (style < 12) ? $urandom_range(12, 9) : $urandom_range(4, 0);
      if (style >= 94) begin
         type_text("exit");
      end else begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) type_byte(CH_SP);
         for (int w = 0; w < word_total; w++) begin
            if (w > 0)
               type_byte(CH_SP);
            if ($urandom_range(5) == 0)
               type_byte(CH_SP);
            repeat ($urandom_range(6, 0)) begin
               type_byte(printable_byte());
               case ($urandom_range(19))
                  0: begin
                     type_byte($urandom_range(1) ? CH_BS : CH_DEL);
                  end
                  1: begin
                     type_byte(ignored_byte());
                  end
                  2: begin
                     read_back();
                  end
                  default: ;
               endcase
            end
         end
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(2, 1)) type_byte(CH_SP);
      end
      type_byte($urandom_range(1) ? CH_CR : CH_LF);
      if ($urandom_range(3) == 0)
         read_back();
   endtask

   initial begin
      send_idle_pct = 15;
      recv_stall_pct <= 77;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edits and ignored bytes on an empty line, then an empty line.
      type_byte(CH_BS);
      type_byte(CH_DEL);
      type_byte(8'h00);
      type_byte(8'hFF);
      type_byte(CH_CR);
      // The exit word, a line of spaces only, and doubled, leading and trailing spaces.
      type_text("exit");
      type_byte(CH_LF);
      type_text("  ");
      type_byte(CH_CR);
      type_text(" ab  c ");
      type_byte(CH_CR);
      // Backspace and delete over content, then a read of a stored byte.
      type_text("xy");
      type_byte(CH_BS);
      type_byte(CH_DEL);
      type_byte(CH_TILDE);
      read_back();
      type_byte(CH_LF);
      // Ten tokens reach the token limit.
      type_text("a b c d e f g h i j");
      type_byte(CH_CR);
      drain_results();

      // Random lines under three idling mixes, each ending with a full drain.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               recv_stall_pct <= 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_stall_pct <= 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
         endcase
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE)
            type_random_line();
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("** console_line_editor_tokenizer_top: PASSED **");
      else
         $display("** console_line_editor_tokenizer_top: FAILED **");
      $finish;
   end

endmodule
